FILE: hdl/hlpg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlpg_pkg
// Types, constants and helpers shared by the heap limit pressure governor.
// ----------------------------------------------------------------------------
package hlpg_pkg;

  localparam int unsigned BYTES_W   = 48;
  localparam int unsigned COUNT_W   = 8;
  localparam int unsigned CFG_ADDR_W = 3;

  localparam logic [BYTES_W-1:0] BYTES_MAX      = '1;
  localparam logic [BYTES_W-1:0] SLACK_BYTES    = 48'd5242880;
  localparam logic [BYTES_W-1:0] GROW_STEP      = 48'd26214400;
  localparam logic [BYTES_W-1:0] LOTS_FREE      = 48'd104857600;
  localparam logic [BYTES_W-1:0] MAX_DROP       = 48'd104857600;
  localparam logic [COUNT_W-1:0] STALE_OVERRIDE = 8'd10;
  localparam logic [COUNT_W-1:0] STALE_MIN_HOLD = 8'd1;
  localparam logic [COUNT_W-1:0] COUNT_SAT      = '1;
  localparam logic [COUNT_W-1:0] MAX_COLL_RST   = 8'd2;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_ADJUST_ENABLE   = 3'd0,
    REG_MAX_HEAP_SIZE   = 3'd1,
    REG_FREE_TARGET     = 3'd2,
    REG_MAX_COLLECTIONS = 3'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [BYTES_W-1:0] heap_total;
    logic [BYTES_W-1:0] heap_free;
    logic [BYTES_W-1:0] avail_physical;
    logic               info_valid;
  } in_t;

  typedef struct packed {
    logic               limit_write;
    logic [BYTES_W-1:0] limit_value;
    logic               collect_trigger;
    logic               resample_wanted;
    logic               info_error;
  } out_t;

  typedef struct packed {
    logic               adjust_enable;
    logic [BYTES_W-1:0] max_heap_size;
    logic [BYTES_W-1:0] free_target;
    logic [COUNT_W-1:0] max_collections;
    logic [BYTES_W-1:0] limit_near;
    logic [BYTES_W-1:0] limit_below;
  } cfg_t;

  typedef struct packed {
    logic [BYTES_W-1:0] soft_limit;
    logic [BYTES_W-1:0] last_heap_size;
    logic [BYTES_W-1:0] peak_free;
    logic [COUNT_W-1:0] stale_free_count;
    logic [COUNT_W-1:0] forced_collections;
  } state_t;

  // Three quarters of a byte count, rounded down.
  function automatic logic [BYTES_W-1:0] three_quarters(input logic [BYTES_W-1:0] v);
    logic [BYTES_W+1:0] sum;
    sum = {2'b00, v} + {1'b0, v, 1'b0};
    return sum[BYTES_W+1:2];
  endfunction

  // One half of a byte count, rounded down.
  function automatic logic [BYTES_W-1:0] one_half(input logic [BYTES_W-1:0] v);
    return {1'b0, v[BYTES_W-1:1]};
  endfunction

endpackage

FILE: hdl/hlpg_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlpg_cfg_regs
// Configuration register file with precomputed shrink limits.
// ----------------------------------------------------------------------------
module hlpg_cfg_regs (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [hlpg_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [hlpg_pkg::BYTES_W-1:0]         cfg_wdata,
  output hlpg_pkg::cfg_t                       cfg,
  output logic                                 max_load
);
  import hlpg_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt  = cfg_r;
    max_load = 1'b0;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_ADJUST_ENABLE: begin
          cfg_nxt.adjust_enable = cfg_wdata[0];
        end
        REG_MAX_HEAP_SIZE: begin
          cfg_nxt.max_heap_size = cfg_wdata;
          cfg_nxt.limit_near    = three_quarters(cfg_wdata);
          cfg_nxt.limit_below   = one_half(cfg_wdata);
          max_load              = 1'b1;
        end
        REG_FREE_TARGET: begin
          cfg_nxt.free_target = cfg_wdata;
        end
        REG_MAX_COLLECTIONS: begin
          cfg_nxt.max_collections = cfg_wdata[COUNT_W-1:0];
        end
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.adjust_enable   <= 1'b0;
      cfg_r.max_heap_size   <= BYTES_MAX;
      cfg_r.free_target     <= '0;
      cfg_r.max_collections <= MAX_COLL_RST;
      cfg_r.limit_near      <= three_quarters(BYTES_MAX);
      cfg_r.limit_below     <= one_half(BYTES_MAX);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: hdl/hlpg_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlpg_step
// Single-pass update of the governor state and result for one sample.
// ----------------------------------------------------------------------------
module hlpg_step (
  input  hlpg_pkg::in_t    item,
  input  hlpg_pkg::cfg_t   cfg,
  input  hlpg_pkg::state_t st,
  output hlpg_pkg::state_t st_next,
  output hlpg_pkg::out_t   result
);
  import hlpg_pkg::*;

  logic               peak_hit;
  logic [COUNT_W-1:0] stale_upd;
  logic               roomy;
  logic [BYTES_W:0]   grow_sum;
  logic [BYTES_W-1:0] grow_lim;
  logic [BYTES_W:0]   raise_sum;
  logic [BYTES_W-1:0] raise_lim;
  logic               grow_hit;
  logic               near_hit;
  logic [BYTES_W-1:0] ratio_lim;
  logic               drop_big;
  logic [BYTES_W-1:0] half_free;
  logic [BYTES_W-1:0] bound;
  logic [BYTES_W-1:0] shrink_lim;
  logic               raise_hit;
  logic [BYTES_W-1:0] new_limit;
  logic               wr;
  logic               coll;
  logic [BYTES_W:0]   slack_old;
  logic [BYTES_W:0]   slack_new;
  logic [COUNT_W-1:0] fc_new;

  always_comb begin
    peak_hit  = st.peak_free >= item.heap_free;
    stale_upd = '0;
    if (peak_hit) begin
      stale_upd = (st.stale_free_count == COUNT_SAT) ? st.stale_free_count
                                                     : st.stale_free_count + 1'b1;
    end
    roomy = (item.heap_free > LOTS_FREE) || (stale_upd > STALE_OVERRIDE);

    grow_sum  = {1'b0, item.heap_total} + {1'b0, GROW_STEP};
    grow_lim  = (grow_sum > {1'b0, cfg.max_heap_size}) ? cfg.max_heap_size
                                                       : grow_sum[BYTES_W-1:0];
    raise_sum = {1'b0, st.soft_limit} + {1'b0, GROW_STEP};
    raise_lim = (raise_sum > {1'b0, cfg.max_heap_size}) ? cfg.max_heap_size
                                                        : raise_sum[BYTES_W-1:0];

    grow_hit = (st.soft_limit <= item.heap_total) &&
               ((st.last_heap_size < item.heap_total) ||
                ((st.last_heap_size == item.heap_total) && (item.heap_free == '0) &&
                 (stale_upd > STALE_MIN_HOLD)));

    near_hit = (cfg.free_target != '0) &&
               ({1'b0, item.avail_physical} <= {cfg.free_target, 1'b0}) && roomy;
    ratio_lim = (item.avail_physical <= cfg.free_target) ? cfg.limit_below
                                                         : cfg.limit_near;
    drop_big  = {2'b00, st.soft_limit} > ({2'b00, ratio_lim} + {2'b00, MAX_DROP});
    half_free = one_half(item.heap_free);
    bound     = (st.soft_limit > half_free) ? st.soft_limit - half_free : '0;
    shrink_lim = (drop_big && (bound > ratio_lim)) ? bound : ratio_lim;

    raise_hit = roomy && (st.soft_limit < cfg.max_heap_size);

    slack_old = {1'b0, st.soft_limit} + {1'b0, SLACK_BYTES};

    new_limit = st.soft_limit;
    wr        = 1'b0;
    coll      = 1'b0;
    fc_new    = st.forced_collections;

    if (item.info_valid && cfg.adjust_enable) begin
      if (grow_hit) begin
        new_limit = grow_lim;
        wr        = 1'b1;
      end else if (near_hit) begin
        new_limit = shrink_lim;
        if (shrink_lim != st.soft_limit) begin
          wr   = 1'b1;
          coll = shrink_lim < item.heap_total;
        end
      end else if (raise_hit) begin
        new_limit = raise_lim;
        wr        = 1'b1;
      end

      if (new_limit != st.soft_limit) begin
        fc_new = '0;
      end else if ((st.forced_collections < cfg.max_collections) &&
                   (item.heap_free > LOTS_FREE) &&
                   ({1'b0, item.heap_total} > slack_old)) begin
        coll   = 1'b1;
        fc_new = (st.last_heap_size == item.heap_total) ? st.forced_collections + 1'b1
                                                        : '0;
      end
    end

    slack_new = {1'b0, new_limit} + {1'b0, SLACK_BYTES};

    st_next.soft_limit         = new_limit;
    st_next.last_heap_size     = item.info_valid ? item.heap_total : st.last_heap_size;
    st_next.peak_free          = peak_hit ? st.peak_free : item.heap_free;
    st_next.stale_free_count   = stale_upd;
    st_next.forced_collections = fc_new;

    result.limit_write     = wr;
    result.limit_value     = new_limit;
    result.collect_trigger = coll;
    result.resample_wanted = ({1'b0, item.heap_total} > slack_new) &&
                             (fc_new < cfg.max_collections);
    result.info_error      = !item.info_valid;
  end

endmodule

FILE: hdl/heap_limit_pressure_governor_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heap_limit_pressure_governor_core
// Soft heap limit governor driven by heap and physical memory samples.
// ----------------------------------------------------------------------------
// The core takes one sample per clock cycle, unless in_stall is raised, and
// returns one result per sample. A sample accepted by the core lands in the
// input register, is evaluated from there, and its result is captured in the
// output register; sustained rate is one sample per cycle while the result
// side keeps up. The rate is set by the state loop: the soft limit, peak free,
// stale count and collection count are read and rewritten in the same cycle
// that evaluates a sample. A write to max_heap_size also reloads the soft
// limit and the peak free tracker.
module heap_limit_pressure_governor_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  hlpg_pkg::in_t                   in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output hlpg_pkg::out_t                  out_data,
  input  logic                            cfg_we,
  input  logic [hlpg_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [hlpg_pkg::BYTES_W-1:0]    cfg_wdata
);
  import hlpg_pkg::*;

  cfg_t   cfg;
  logic   max_load;
  state_t st_r;
  state_t st_nxt;
  state_t st_step;
  out_t   result;

  logic   s1_valid_r;
  logic   s1_valid_nxt;
  in_t    s1_data_r;
  logic   out_valid_r;
  logic   out_valid_nxt;
  out_t   out_data_r;
  logic   out_free;
  logic   proc;
  logic   in_take;

  hlpg_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .cfg      (cfg),
    .max_load (max_load)
  );

  hlpg_step u_step (
    .item   (s1_data_r),
    .cfg    (cfg),
    .st     (st_r),
    .st_next(st_step),
    .result (result)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign proc     = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (proc) begin
      s1_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (proc) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end

    st_nxt = st_r;
    if (proc) begin
      st_nxt = st_step;
    end
    if (max_load) begin
      st_nxt.soft_limit = cfg_wdata;
      st_nxt.peak_free  = cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r                 <= 1'b0;
      out_valid_r                <= 1'b0;
      st_r.soft_limit            <= BYTES_MAX;
      st_r.last_heap_size        <= '0;
      st_r.peak_free             <= BYTES_MAX;
      st_r.stale_free_count      <= '0;
      st_r.forced_collections    <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      st_r        <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data_r <= in_data;
    end
    if (proc) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("input stalled with an empty input register");

  a_rise_after_proc: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(proc))
    else $error("result appeared without an evaluated sample");

  a_invalid_holds_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && !s1_data_r.info_valid && !max_load) |=> $stable(st_r.soft_limit))
    else $error("soft limit moved on an invalid sample");

  a_stale_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && st_r.stale_free_count == COUNT_SAT &&
     st_r.peak_free >= s1_data_r.heap_free) |=> st_r.stale_free_count == COUNT_SAT)
    else $error("stale free count wrapped");

  a_write_needs_info: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.limit_write) |-> !out_data_r.info_error)
    else $error("limit write issued for a sample without memory info");

endmodule
